[rtl/core/kpc_pkg.sv]
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types and constants of the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

    // Per-key debounce phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_PRESSED = 2'd2,
        PH_HELD    = 2'd3
    } phase_t;

    // Reported event code
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_LONG_PRESS    = 2'd0;
    localparam logic [1:0] CFG_RELEASE_CHECK = 2'd1;
    localparam logic [1:0] CFG_PRESSED_LEVEL = 2'd2;

    // Register reset values
    localparam logic [7:0] LONG_PRESS_RESET    = 8'd100;
    localparam logic [7:0] RELEASE_CHECK_RESET = 8'd10;
    localparam logic       PRESSED_LEVEL_RESET = 1'b0;

    localparam logic [7:0] TICKS_MAX = 8'd255;

    // One stored key entry
    typedef struct packed {
        phase_t     phase;
        logic [7:0] ticks;
    } entry_t;

    // Tick thresholds
    typedef struct packed {
        logic [7:0] long_press_ticks;
        logic [7:0] release_check_ticks;
    } kpc_cfg_t;

endpackage

[rtl/core/kpc_ram.sv]
// ----------------------------------------------------------------------------
// kpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kpc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port (old data on same-edge write)
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/kpc_key_fsm.sv]
// ----------------------------------------------------------------------------
// kpc_key_fsm
// Next phase, tick count and event for one key sample.
// ----------------------------------------------------------------------------
module kpc_key_fsm (
    input  kpc_pkg::entry_t   cur,
    input  logic              pressed,
    input  kpc_pkg::kpc_cfg_t cfg,
    output kpc_pkg::entry_t   nxt,
    output kpc_pkg::event_t   press_event
);

    logic [7:0]      ticks_inc;
    logic            long_hit;
    logic            check_hit;
    kpc_pkg::phase_t nxt_phase;
    logic [7:0]      nxt_ticks;

    // Saturating tick count
    assign ticks_inc = (cur.ticks == kpc_pkg::TICKS_MAX) ? kpc_pkg::TICKS_MAX
                                                         : cur.ticks + 8'd1;
    assign long_hit  = (ticks_inc >= cfg.long_press_ticks);
    assign check_hit = (ticks_inc >= cfg.release_check_ticks);

    // Next phase
    always_comb
    begin
        nxt_phase = cur.phase;
        unique case (cur.phase)
            kpc_pkg::PH_IDLE:
            begin
                if (pressed)
                begin
                    nxt_phase = kpc_pkg::PH_CONFIRM;
                end
            end
            kpc_pkg::PH_CONFIRM:
            begin
                nxt_phase = pressed ? kpc_pkg::PH_PRESSED : kpc_pkg::PH_IDLE;
            end
            kpc_pkg::PH_PRESSED:
            begin
                if (!pressed)
                begin
                    nxt_phase = kpc_pkg::PH_IDLE;
                end
                else if (long_hit)
                begin
                    nxt_phase = kpc_pkg::PH_HELD;
                end
            end
            kpc_pkg::PH_HELD:
            begin
                if (check_hit && !pressed)
                begin
                    nxt_phase = kpc_pkg::PH_IDLE;
                end
            end
            default:
            begin
                nxt_phase = kpc_pkg::PH_IDLE;
            end
        endcase
    end

    // Tick count and event
    always_comb
    begin
        nxt_ticks   = ticks_inc;
        press_event = kpc_pkg::EV_NONE;
        unique case (cur.phase)
            kpc_pkg::PH_IDLE,
            kpc_pkg::PH_CONFIRM:
            begin
                if (pressed)
                begin
                    nxt_ticks = 8'd0;
                end
            end
            kpc_pkg::PH_PRESSED:
            begin
                if (!pressed)
                begin
                    nxt_ticks   = 8'd0;
                    press_event = kpc_pkg::EV_SHORT;
                end
                else if (long_hit)
                begin
                    nxt_ticks   = 8'd0;
                    press_event = kpc_pkg::EV_LONG;
                end
            end
            kpc_pkg::PH_HELD:
            begin
                if (check_hit)
                begin
                    nxt_ticks = 8'd0;
                end
            end
            default:
            begin
                nxt_ticks = ticks_inc;
            end
        endcase
    end

    // Pack next entry
    assign nxt = '{phase: nxt_phase, ticks: nxt_ticks};

endmodule

[rtl/core/key_press_classifier_top.sv]
// ----------------------------------------------------------------------------
// key_press_classifier_top
// Debounced short/long press detection for several keys sampled per tick.
// ----------------------------------------------------------------------------
// The block takes one key sample per cycle unless the output stalls, and
// returns exactly one result per sample, via the update stage and output register.
// The per-key phase and tick counter live in one RAM with a registered read: a
// sample reads its key's entry in the transfer cycle, the update stage updates it
// and writes it back when it advances, and the most recent write is forwarded to
// a sample of the same key that follows directly. A valid bit per key makes
// entries read as idle with zero ticks after reset, so no clearing pass is
// needed. Samples with a key index not below NUM_KEYS leave all state untouched
// and report no event. Thresholds must be written by the user through the cfg
// port while no sample is in flight; the block itself does not enforce this.
module key_press_classifier_top #(
    parameter int NUM_KEYS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // Sample input
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [2:0] key_index, [3] key_level, zero pad
    // Event output
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [2:0] event_key, [4:3] press_event, zero pad
);

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int EW = $bits(kpc_pkg::entry_t);

    // Configuration registers
    logic [7:0] long_press_reg;
    logic [7:0] release_check_reg;
    logic       pressed_level_reg;

    // Input decode
    logic [2:0]    in_key;
    logic          in_level;
    logic [AW+2:0] in_key_ext;
    logic [AW-1:0] in_addr;
    logic          in_range;
    logic          in_xfer;

    // Update stage
    logic          s1_valid_reg;
    logic [2:0]    s1_key_reg;
    logic          s1_level_reg;
    logic          s1_range_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          rd_valid_reg;
    logic          s1_adv;

    // Last write, for forwarding
    logic            fwd_valid_reg;
    logic [AW-1:0]   fwd_addr_reg;
    kpc_pkg::entry_t fwd_entry_reg;

    logic [NUM_KEYS-1:0] entry_valid_reg;

    logic [EW-1:0]     ram_rdata;
    kpc_pkg::entry_t   cur_entry;
    kpc_pkg::entry_t   nxt_entry;
    kpc_pkg::event_t   fsm_event;
    kpc_pkg::kpc_cfg_t fsm_cfg;
    logic              pressed;
    logic              wr_en;

    // Output register
    logic            out_valid_reg;
    logic [2:0]      out_key_reg;
    kpc_pkg::event_t out_event_reg;

    // Configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg    <= kpc_pkg::LONG_PRESS_RESET;
            release_check_reg <= kpc_pkg::RELEASE_CHECK_RESET;
            pressed_level_reg <= kpc_pkg::PRESSED_LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                kpc_pkg::CFG_LONG_PRESS:    long_press_reg    <= cfg_data;
                kpc_pkg::CFG_RELEASE_CHECK: release_check_reg <= cfg_data;
                kpc_pkg::CFG_PRESSED_LEVEL: pressed_level_reg <= cfg_data[0];
                default:                    long_press_reg    <= long_press_reg;
            endcase
        end
    end

    // Input decode and handshake
    assign in_key     = s_axis_tdata[2:0];
    assign in_level   = s_axis_tdata[3];
    assign in_key_ext = {{AW{1'b0}}, in_key};
    assign in_addr    = in_key_ext[AW-1:0];
    assign in_range   = (32'(in_key) < 32'(NUM_KEYS));

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Key state memory
    kpc_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_KEYS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (nxt_entry),
        .rd_en   (in_xfer),
        .rd_addr (in_addr),
        .rd_data (ram_rdata)
    );

    // Update stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_key_reg   <= in_key;
            s1_level_reg <= in_level;
            s1_range_reg <= in_range;
            s1_addr_reg  <= in_addr;
            rd_valid_reg <= in_range && entry_valid_reg[in_addr];
        end
    end

    // Entry select: last write, stored entry, or reset value
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            cur_entry = fwd_entry_reg;
        end
        else if (rd_valid_reg)
        begin
            cur_entry = kpc_pkg::entry_t'(ram_rdata);
        end
        else
        begin
            cur_entry = '{phase: kpc_pkg::PH_IDLE, ticks: 8'd0};
        end
    end

    assign pressed = (s1_level_reg == pressed_level_reg);
    assign fsm_cfg = '{long_press_ticks: long_press_reg,
                       release_check_ticks: release_check_reg};

    kpc_key_fsm u_key_fsm (
        .cur         (cur_entry),
        .pressed     (pressed),
        .cfg         (fsm_cfg),
        .nxt         (nxt_entry),
        .press_event (fsm_event)
    );

    assign wr_en = s1_adv && s1_range_reg;

    // Valid bits and forwarding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            entry_valid_reg[s1_addr_reg] <= 1'b1;
            fwd_valid_reg                <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg  <= s1_addr_reg;
            fwd_entry_reg <= nxt_entry;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_key_reg   <= s1_key_reg;
            out_event_reg <= s1_range_reg ? fsm_event : kpc_pkg::EV_NONE;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_event_reg, out_key_reg};

    // Checks
    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> m_axis_tvalid)
        else $error("update stage advanced but no result presented");

    a_short_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_range_reg && fsm_event == kpc_pkg::EV_SHORT) |=>
        (fwd_valid_reg && fwd_entry_reg.phase == kpc_pkg::PH_IDLE))
        else $error("short press did not return key to idle");

    a_long_to_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_range_reg && fsm_event == kpc_pkg::EV_LONG) |=>
        (fwd_valid_reg && fwd_entry_reg.phase == kpc_pkg::PH_HELD
         && fwd_entry_reg.ticks == 8'd0))
        else $error("long press did not enter held phase with cleared ticks");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:3] != 2'd3 && m_axis_tdata[7:5] == 3'd0))
        else $error("invalid event code on output");

endmodule

[dv/key_press_classifier_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_press_classifier_top_tb
// Self-checking bench for the short/long key press classifier.
// ----------------------------------------------------------------------------
// Key samples are queued by the stimulus process and sent by a driver with
// random idle bursts. A monitor runs a per-key debounce predictor on every
// accepted sample and checks each event transfer against the oldest
// expected event. Directed sequences cover short and long presses, threshold
// extremes including zero, counter saturation and both pressed levels.
// Random phases follow, each with fresh thresholds. The sink stalls at
// random, including one long hold-off, and once the source waits until all
// pending events have come back.
module key_press_classifier_top_tb;

    localparam int NUM_KEYS    = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [2:0] key;
        logic       level;
    } key_sample_t;

    typedef struct packed {
        logic [2:0]      key;
        kpc_pkg::event_t ev;
    } key_event_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = kpc_pkg::CFG_LONG_PRESS;
    logic [7:0] cfg_data = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    // Predictor state and register copies
    kpc_pkg::phase_t key_phase_q [NUM_KEYS];
    logic [7:0]      key_ticks_q [NUM_KEYS];
    logic [7:0]      long_ticks  = kpc_pkg::LONG_PRESS_RESET;
    logic [7:0]      check_ticks = kpc_pkg::RELEASE_CHECK_RESET;
    logic            press_level = kpc_pkg::PRESSED_LEVEL_RESET;

    key_sample_t sample_queue[$];
    key_event_t  expected_events[$];

    int  n_queued   = 0;
    int  n_accepted = 0;
    int  n_errors   = 0;
    int  cycles     = 0;
    int  tx_gap     = 0;
    int  rx_gap     = 0;
    int  rx_hold    = 0;
    bit  tx_pause   = 1'b0;
    bit  no_idle    = 1'b0;
    logic in_fire   = 1'b0;

    key_press_classifier_top #(
        .NUM_KEYS(NUM_KEYS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Per-key debounce: returns the event caused by one sample
    function automatic kpc_pkg::event_t classify_sample(input logic [2:0] key,
                                                        input logic level);
        logic            pressed;
        kpc_pkg::event_t ev;
        pressed = (level == press_level);
        ev = kpc_pkg::EV_NONE;
        if (int'(key) < NUM_KEYS)
        begin
            if (key_ticks_q[key] != kpc_pkg::TICKS_MAX)
                key_ticks_q[key] = key_ticks_q[key] + 8'd1;
            case (key_phase_q[key])
                kpc_pkg::PH_IDLE:
                begin
                    if (pressed)
                    begin
                        key_ticks_q[key] = '0;
                        key_phase_q[key] = kpc_pkg::PH_CONFIRM;
                    end
                end
                kpc_pkg::PH_CONFIRM:
                begin
                    if (pressed)
                    begin
                        key_ticks_q[key] = '0;
                        key_phase_q[key] = kpc_pkg::PH_PRESSED;
                    end
                    else
                        key_phase_q[key] = kpc_pkg::PH_IDLE;
                end
                kpc_pkg::PH_PRESSED:
                begin
                    if (!pressed)
                    begin
                        key_ticks_q[key] = '0;
                        key_phase_q[key] = kpc_pkg::PH_IDLE;
                        ev = kpc_pkg::EV_SHORT;
                    end
                    else if (key_ticks_q[key] >= long_ticks)
                    begin
                        key_ticks_q[key] = '0;
                        key_phase_q[key] = kpc_pkg::PH_HELD;
                        ev = kpc_pkg::EV_LONG;
                    end
                end
                default:
                begin
                    // held: level is only looked at on the check interval
                    if (key_ticks_q[key] >= check_ticks)
                    begin
                        key_ticks_q[key] = '0;
                        if (!pressed)
                            key_phase_q[key] = kpc_pkg::PH_IDLE;
                    end
                end
            endcase
        end
        return ev;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // Monitor: predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        key_event_t exp_ev;
        key_sample_t smp;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                smp.key   = s_axis_tdata[2:0];
                smp.level = s_axis_tdata[3];
                exp_ev.key = smp.key;
                exp_ev.ev  = classify_sample(smp.key, smp.level);
                expected_events.push_back(exp_ev);
                n_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("unexpected event transfer 0x%02h",
                                              m_axis_tdata));
                else
                begin
                    exp_ev = expected_events.pop_front();
                    if (m_axis_tdata[2:0] != exp_ev.key)
                        report_mismatch($sformatf("event_key %0d, expected %0d",
                                                  m_axis_tdata[2:0], exp_ev.key));
                    if (m_axis_tdata[4:3] != exp_ev.ev)
                        report_mismatch($sformatf("key %0d press_event %0d, expected %0d",
                                                  exp_ev.key, m_axis_tdata[4:3], exp_ev.ev));
                    if (m_axis_tdata[7:5] != 3'b000)
                        report_mismatch($sformatf("nonzero pad bits 0x%02h", m_axis_tdata));
                end
            end
        end
    end

    // Sample driver with random idle bursts
    always @(negedge clk)
    begin
        key_sample_t smp;
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (!tx_pause && sample_queue.size() > 0)
            begin
                smp = sample_queue.pop_front();
                s_axis_tdata  <= {4'b0000, smp.level, smp.key};
                s_axis_tvalid <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0)
                    tx_gap = $urandom_range(1, 6);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Event sink: random stall bursts plus an optional long hold-off
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 7) == 0)
                rx_gap = $urandom_range(1, 6);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** key_press_classifier_top: FAILED **");
            $finish;
        end
    end

    task automatic queue_sample(input logic [2:0] key, input logic level);
        key_sample_t smp;
        smp.key   = key;
        smp.level = level;
        sample_queue.push_back(smp);
        n_queued++;
    endtask

    // Wait until every sample is accepted and every event returned
    task automatic wait_all_done();
        while (n_accepted != n_queued || expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            kpc_pkg::CFG_LONG_PRESS:    long_ticks  = val;
            kpc_pkg::CFG_RELEASE_CHECK: check_ticks = val;
            kpc_pkg::CFG_PRESSED_LEVEL: press_level = val[0];
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [7:0] lp, input logic [7:0] rc, input logic pl);
        write_reg(kpc_pkg::CFG_LONG_PRESS, lp);
        write_reg(kpc_pkg::CFG_RELEASE_CHECK, rc);
        write_reg(kpc_pkg::CFG_PRESSED_LEVEL, {7'd0, pl});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed presses on random keys, some noise in between
    task automatic queue_random_presses(input int n_items);
        int start;
        int hold_len;
        int rel_len;
        int hold_max;
        logic [2:0] key;
        start = n_queued;
        while (n_queued - start < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                key = 3'($urandom_range(0, NUM_KEYS - 1));
                hold_max = int'(long_ticks) + 2 * int'(check_ticks) + 4;
                if (hold_max > 60)
                    hold_max = 60;
                hold_len = $urandom_range(1, hold_max);
                rel_len  = $urandom_range(1, 3);
                for (int i = 0; i < hold_len; i++)
                begin
                    queue_sample(key, press_level);
                    if ($urandom_range(0, 3) == 0)
                        queue_sample(3'($urandom_range(0, NUM_KEYS - 1)),
                                     1'($urandom_range(0, 1)));
                end
                for (int i = 0; i < rel_len; i++)
                    queue_sample(key, ~press_level);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    queue_sample(3'($urandom_range(0, NUM_KEYS - 1)),
                                 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Stimulus
    initial
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_phase_q[k] = kpc_pkg::PH_IDLE;
            key_ticks_q[k] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset thresholds, pressed level low: glitch, short presses
        queue_sample(3'd0, 1'b1);
        queue_sample(3'd0, 1'b0);
        queue_sample(3'd0, 1'b1);
        queue_sample(3'd7, 1'b0);
        queue_sample(3'd7, 1'b0);
        queue_sample(3'd7, 1'b1);
        repeat (4) queue_sample(3'd3, 1'b0);
        queue_sample(3'd3, 1'b1);
        wait_all_done();

        // Thresholds of one, pressed level high: long press, release check
        write_settings(8'd1, 8'd1, 1'b1);
        repeat (4) queue_sample(3'd2, 1'b1);
        queue_sample(3'd2, 1'b0);
        queue_sample(3'd6, 1'b1);
        queue_sample(3'd6, 1'b1);
        queue_sample(3'd6, 1'b0);
        wait_all_done();

        // Zero thresholds: long press at once, release checked every sample
        write_settings(8'd0, 8'd0, 1'b0);
        repeat (3) queue_sample(3'd1, 1'b0);
        queue_sample(3'd1, 1'b1);
        queue_sample(3'd4, 1'b0);
        queue_sample(3'd4, 1'b0);
        queue_sample(3'd4, 1'b1);
        wait_all_done();

        // Largest thresholds: long press at 255, idle counter saturates
        write_settings(8'd255, 8'd255, 1'b1);
        for (int i = 0; i < 268; i++)
        begin
            queue_sample(3'd5, press_level);
            queue_sample(3'd0, ~press_level);
        end
        queue_sample(3'd0, press_level);
        queue_sample(3'd0, press_level);
        queue_sample(3'd0, ~press_level);
        queue_sample(3'd5, ~press_level);
        wait_all_done();

        // Random phases
        for (int ph = 0; ph < 4; ph++)
        begin
            write_settings(8'($urandom_range(0, 24)), 8'($urandom_range(0, 12)),
                           1'($urandom_range(0, 1)));
            if (ph == 0)
                rx_hold = 150;
            if (ph == 3)
                no_idle = 1'b1;
            if (ph == 1)
            begin
                queue_random_presses(70);
                while (sample_queue.size() != 0)
                    @(posedge clk);
                tx_pause = 1'b1;
                while (n_accepted != n_queued || expected_events.size() != 0)
                    @(posedge clk);
                tx_pause = 1'b0;
                queue_random_presses(70);
            end
            else
                queue_random_presses(140);
            wait_all_done();
        end

        if (n_errors == 0)
            $display("** key_press_classifier_top: PASSED **");
        else
            $display("** key_press_classifier_top: FAILED **");
        $finish;
    end

endmodule
